FILE: rtl/grw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grw_pkg
// Shared types and constants for the Gaussian random walk barrier block.
// ----------------------------------------------------------------------------
package grw_pkg;

  localparam int FRACTION_BITS = 24;
  localparam int COUNT_WIDTH   = 32;

  localparam logic [29:0] LN2_Q30     = 30'd744261118;
  localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

  // Reciprocals ceil(2^(31+l)/d) with 2^l >= d; exact floor(n/d) for n < 2^31
  localparam logic [31:0] RCP_72 = 32'(((64'd1 << 38) + 64'd71) / 64'd72);
  localparam logic [31:0] RCP_42 = 32'(((64'd1 << 37) + 64'd41) / 64'd42);
  localparam logic [31:0] RCP_20 = 32'(((64'd1 << 36) + 64'd19) / 64'd20);
  localparam logic [31:0] RCP_6  = 32'(((64'd1 << 34) + 64'd5) / 64'd6);
  localparam logic [31:0] RCP_90 = 32'(((64'd1 << 38) + 64'd89) / 64'd90);
  localparam logic [31:0] RCP_56 = 32'(((64'd1 << 37) + 64'd55) / 64'd56);
  localparam logic [31:0] RCP_30 = 32'(((64'd1 << 36) + 64'd29) / 64'd30);
  localparam logic [31:0] RCP_12 = 32'(((64'd1 << 35) + 64'd11) / 64'd12);
  localparam logic [31:0] RCP_2  = 32'(((64'd1 << 32) + 64'd1) / 64'd2);

  // Configuration register indexes
  localparam logic [1:0] REG_UPPER = 2'd0;
  localparam logic [1:0] REG_LOWER = 2'd1;
  localparam logic [1:0] REG_SCALE = 2'd2;
  localparam logic [1:0] REG_DRIFT = 2'd3;

  typedef struct packed {
    logic [31:0] uniform_radius;
    logic [31:0] uniform_angle;
  } in_item_t;

  typedef struct packed {
    logic        reached_upper;
    logic [31:0] walk_length;
    logic [31:0] final_position;
    logic [31:0] upper_total;
    logic [31:0] lower_total;
  } out_item_t;

  // Normal sample handed from front to back: magnitude Q.30*Q.28 product
  // before the final shift, and its sign
  typedef struct packed {
    logic        neg;
    logic [63:0] prod;
  } sample_t;

  // Reciprocal and shift of the Horner divisors, step i of 0..4
  function automatic logic [31:0] sin_rcp(input logic [2:0] i);
    case (i)
      3'd0:    sin_rcp = RCP_72;
      3'd1:    sin_rcp = RCP_42;
      3'd2:    sin_rcp = RCP_20;
      default: sin_rcp = RCP_6;
    endcase
  endfunction

  function automatic logic [5:0] sin_sh(input logic [2:0] i);
    case (i)
      3'd0:    sin_sh = 6'd38;
      3'd1:    sin_sh = 6'd37;
      3'd2:    sin_sh = 6'd36;
      default: sin_sh = 6'd34;
    endcase
  endfunction

  function automatic logic [31:0] cos_rcp(input logic [2:0] i);
    case (i)
      3'd0:    cos_rcp = RCP_90;
      3'd1:    cos_rcp = RCP_56;
      3'd2:    cos_rcp = RCP_30;
      3'd3:    cos_rcp = RCP_12;
      default: cos_rcp = RCP_2;
    endcase
  endfunction

  function automatic logic [5:0] cos_sh(input logic [2:0] i);
    case (i)
      3'd0:    cos_sh = 6'd38;
      3'd1:    cos_sh = 6'd37;
      3'd2:    cos_sh = 6'd36;
      3'd3:    cos_sh = 6'd35;
      default: cos_sh = 6'd32;
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: rtl/gaussian_random_walk_barrier_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_random_walk_barrier_core
// Box-Muller Gaussian random walk between two absorbing barriers.
// ----------------------------------------------------------------------------
// Usage:
//   Push pairs of 32-bit uniforms on in_push/in_full. Each pair makes one
//   normal step; a result appears on the out_ queue only when the walk hits
//   a barrier, then the walk restarts at 0.
//   Configuration (cfg_we/cfg_index/cfg_data) is for the user to write only
//   while idle; the block itself does not enforce it.
// Front steps: the sampler normalizes the radius one leading zero at a
//   time, then runs 32 log2 squarings, 33 square root steps, ten Horner
//   steps and the ln, theta, t2, sine, product and done steps. A two-entry
//   sample queue lets the front take the next item while the back scales
//   and steps the walk.
// Reset: clears the walk, tallies and queues; registers go to 1.0, 2.0,
//   1.0 and 0. A stalled receiver fills the one-entry result register and
//   then the sample queue; in_full rises and items are held off.
// ----------------------------------------------------------------------------
module gaussian_random_walk_barrier_core #(
  parameter int FRACTION_BITS = grw_pkg::FRACTION_BITS,
  parameter int COUNT_WIDTH   = grw_pkg::COUNT_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  input  wire grw_pkg::in_item_t  in_data,
  output logic                    in_full,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output grw_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  logic [30:0]        upper_r, lower_r, scale_r;
  logic signed [31:0] drift_r;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= 31'd16777216;
      lower_r <= 31'd33554432;
      scale_r <= 31'd16777216;
      drift_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        grw_pkg::REG_UPPER: upper_r <= cfg_data[30:0];
        grw_pkg::REG_LOWER: lower_r <= cfg_data[30:0];
        grw_pkg::REG_SCALE: scale_r <= cfg_data[30:0];
        grw_pkg::REG_DRIFT: drift_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic             f_busy, f_done, b_busy, b_hit;
  grw_pkg::sample_t f_sample;
  grw_pkg::sample_t q_r [2];
  logic [1:0]       q_cnt_r;
  logic             q_rd_r;
  logic             q_wr_r;
  logic             out_v_r;
  logic             b_start;
  logic             in_acc;
  grw_pkg::out_item_t b_res;

  assign in_acc  = in_push && !in_full;
  // Admit only while a queue slot is sure to be free
  assign in_full = f_busy || (q_cnt_r == 2'd2);
  // Back starts only when a result slot is free
  assign b_start = (q_cnt_r != 2'd0) && !b_busy && !b_hit && !out_v_r;

  grw_front u_front (
    .clk(clk), .rst_n(rst_n), .start(in_acc), .item(in_data),
    .busy(f_busy), .done(f_done), .sample(f_sample)
  );

  // Advance the sample queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
      q_rd_r  <= 1'b0;
      q_wr_r  <= 1'b0;
    end else begin
      if (f_done) begin
        q_r[q_wr_r] <= f_sample;
        q_wr_r      <= !q_wr_r;
      end
      if (b_start) q_rd_r <= !q_rd_r;
      q_cnt_r <= q_cnt_r + {1'b0, f_done} - {1'b0, b_start};
    end
  end

  grw_back #(.FRACTION_BITS(FRACTION_BITS), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .start(b_start), .sample(q_r[q_rd_r]),
    .upper_barrier(upper_r), .lower_barrier(lower_r), .step_scale(scale_r),
    .drift(drift_r), .busy(b_busy), .hit(b_hit), .result(b_res)
  );

  // Hold one result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (b_hit) begin
      out_v_r  <= 1'b1;
      out_data <= b_res;
    end else if (out_pop && out_v_r) begin
      out_v_r <= 1'b0;
    end
  end
  assign out_empty = !out_v_r;

  assert property (@(posedge clk) disable iff (!rst_n) q_cnt_r != 2'd3)
    else $error("sample queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) b_hit |-> !out_v_r)
    else $error("result overwritten");
  assert property (@(posedge clk) disable iff (!rst_n) f_done |-> q_cnt_r != 2'd2)
    else $error("sample dropped");

endmodule

`default_nettype wire

FILE: rtl/grw_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grw_front
// Box-Muller sampler: turns one pair of uniforms into a signed normal
// sample using a sequenced log2, square root and Taylor sine/cosine.
// ----------------------------------------------------------------------------
module grw_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire grw_pkg::in_item_t  item,
  output logic                    busy,
  output logic                    done,
  output grw_pkg::sample_t        sample
);

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_LOG, S_LN, S_SQRT, S_THETA, S_T2,
    S_HORN_MUL, S_HORN_DIV, S_SIN, S_MUL, S_DONE
  } state_t;

  state_t       state_r;
  logic [31:0]  u_r;
  logic [32:0]  x_r;
  logic [31:0]  frac_r;
  logic [5:0]   p_r;
  logic [5:0]   cnt_r;
  logic [63:0]  w_r;       // sqrt remainder / operand
  logic [63:0]  res_r;
  logic [63:0]  bit_r;
  logic [31:0]  a_r;
  logic [30:0]  theta_r;
  logic [30:0]  t2_r;
  logic [30:0]  hs_r;
  logic [30:0]  hc_r;
  logic [30:0]  ps_r;
  logic [30:0]  pc_r;
  logic [2:0]   hi_r;
  logic         fneg_r;
  logic [63:0]  prod_r;
  logic         neg_r;

  logic [65:0]  sq;
  logic [29:0]  mag;
  logic [63:0]  thp;
  logic [61:0]  t2p;
  logic [61:0]  mhs;
  logic [61:0]  mhc;
  logic [61:0]  sinp;
  logic [63:0]  tsum;
  logic [63:0]  tval;
  logic [95:0]  lnp;
  logic [62:0]  qsp;
  logic [62:0]  qcp;
  logic [30:0]  qs;
  logic [30:0]  qc;
  logic [1:0]   quad;
  logic [30:0]  cmag;
  logic         cneg;

  assign sq   = {33'd0, x_r} * {33'd0, x_r};
  assign mag  = a_r[29] ? (a_r[29:0] - 30'h2000_0000) : (30'h2000_0000 - a_r[29:0]);
  assign thp  = {34'd0, mag} * {33'd0, grw_pkg::PI_HALF_Q30};
  assign t2p  = {31'd0, theta_r} * {31'd0, theta_r};
  assign mhs  = {31'd0, t2_r} * {31'd0, hs_r};
  assign mhc  = {31'd0, t2_r} * {31'd0, hc_r};
  assign sinp = {31'd0, theta_r} * {31'd0, hs_r};
  assign tval = {26'd0, (6'd32 - p_r), 32'd0} - {32'd0, frac_r};
  assign tsum = tval >> 4;
  assign lnp  = {32'd0, tsum} * {66'd0, grw_pkg::LN2_Q30};
  // Divide by the Horner divisor through its reciprocal
  assign qsp  = {32'd0, ps_r} * {31'd0, grw_pkg::sin_rcp(hi_r)};
  assign qcp  = {32'd0, pc_r} * {31'd0, grw_pkg::cos_rcp(hi_r)};
  assign qs   = 31'(qsp >> grw_pkg::sin_sh(hi_r));
  assign qc   = 31'(qcp >> grw_pkg::cos_sh(hi_r));
  assign quad = a_r[31:30];
  assign cmag = (quad[0]) ? ps_r : hc_r;
  always_comb begin
    case (quad)
      2'd0:    cneg = 1'b0;
      2'd1:    cneg = !fneg_r;
      2'd2:    cneg = 1'b1;
      default: cneg = fneg_r;
    endcase
  end

  assign busy   = (state_r != S_IDLE);
  assign done   = (state_r == S_DONE);
  assign sample = '{neg: neg_r, prod: prod_r};

  // Sequence one item through log, sqrt and cosine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            u_r     <= (item.uniform_radius == 32'd0) ? 32'd1 : item.uniform_radius;
            a_r     <= item.uniform_angle + 32'h2000_0000;
            p_r     <= 6'd31;
            state_r <= S_NORM;
          end
        end
        // find the leading one, one bit a cycle
        S_NORM: begin
          if (u_r[31]) begin
            x_r     <= {1'b0, u_r};
            frac_r  <= '0;
            cnt_r   <= '0;
            state_r <= S_LOG;
          end else begin
            u_r <= u_r << 1;
            p_r <= p_r - 6'd1;
          end
        end
        // one squaring per fraction bit
        S_LOG: begin
          if (sq[63]) begin
            x_r <= sq[64:32];
            frac_r[5'd31 - cnt_r[4:0]] <= 1'b1;
          end else begin
            x_r <= sq[63:31];
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd31) state_r <= S_LN;
        end
        S_LN: begin
          w_r     <= {lnp[64:29], 28'd0};
          res_r   <= '0;
          bit_r   <= 64'h4000_0000_0000_0000;
          state_r <= S_SQRT;
        end
        // restoring square root, two bits a step
        S_SQRT: begin
          if (bit_r == 64'd0) begin
            state_r <= S_THETA;
          end else if (w_r >= res_r + bit_r) begin
            w_r   <= w_r - (res_r + bit_r);
            res_r <= (res_r >> 1) + bit_r;
            bit_r <= bit_r >> 2;
          end else begin
            res_r <= res_r >> 1;
            bit_r <= bit_r >> 2;
          end
        end
        S_THETA: begin
          fneg_r  <= !a_r[29];
          theta_r <= thp[60:30];
          state_r <= S_T2;
        end
        S_T2: begin
          t2_r    <= t2p[60:30];
          hs_r    <= grw_pkg::ONE_Q30;
          hc_r    <= grw_pkg::ONE_Q30;
          hi_r    <= '0;
          state_r <= S_HORN_MUL;
        end
        S_HORN_MUL: begin
          ps_r    <= mhs[60:30];
          pc_r    <= mhc[60:30];
          state_r <= S_HORN_DIV;
        end
        // division by a small constant from the table
        S_HORN_DIV: begin
          if (hi_r != 3'd4) hs_r <= grw_pkg::ONE_Q30 - qs;
          hc_r <= grw_pkg::ONE_Q30 - qc;
          hi_r <= hi_r + 3'd1;
          state_r <= (hi_r == 3'd4) ? S_SIN : S_HORN_MUL;
        end
        S_SIN: begin
          ps_r    <= sinp[60:30];
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= {28'd0, res_r[35:0]} * {33'd0, cmag};
          neg_r   <= cneg;
          state_r <= S_DONE;
        end
        S_DONE:  state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  logic unused;
  assign unused = ^{sq[65], thp[63:61], thp[29:0], t2p[61], t2p[29:0], mhs[61],
                    mhs[29:0], mhc[61], mhc[29:0], sinp[61], sinp[29:0], lnp[95:65],
                    lnp[28:0], res_r[63:36]};

endmodule

`default_nettype wire

FILE: rtl/grw_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grw_back
// Walk state: scales a sample, steps the position, tests the barriers
// and keeps the tallies.
// ----------------------------------------------------------------------------
module grw_back #(
  parameter int FRACTION_BITS = grw_pkg::FRACTION_BITS,
  parameter int COUNT_WIDTH   = grw_pkg::COUNT_WIDTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire grw_pkg::sample_t  sample,
  input  wire logic [30:0]       upper_barrier,
  input  wire logic [30:0]       lower_barrier,
  input  wire logic [30:0]       step_scale,
  input  wire logic signed [31:0] drift,
  output logic                   busy,
  output logic                   hit,
  output grw_pkg::out_item_t     result
);

  localparam int ZSH = 58 - FRACTION_BITS;
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  typedef enum logic [1:0] {B_IDLE, B_SCALE, B_STEP} state_t;

  state_t                  state_r;
  logic [31:0]             z_r;
  logic                    neg_r;
  logic [63:0]             smag_r;
  logic signed [31:0]      pos_r;
  logic [COUNT_WIDTH-1:0]  steps_r;
  logic [COUNT_WIDTH-1:0]  up_r;
  logic [COUNT_WIDTH-1:0]  dn_r;

  logic [63:0]             sp;
  logic signed [66:0]      np;
  logic signed [31:0]      npos;
  logic [COUNT_WIDTH-1:0]  steps_n;
  logic [COUNT_WIDTH-1:0]  up_n;
  logic [COUNT_WIDTH-1:0]  dn_n;
  logic                    is_up;
  logic                    is_dn;

  function automatic logic [31:0] clip(input logic [COUNT_WIDTH-1:0] c);
    if (COUNT_WIDTH > 32 && (c >> 32) != '0) clip = 32'hFFFF_FFFF;
    else clip = 32'(c);
  endfunction

  // The normal magnitude stays below 2^31 for fraction widths up to 28
  assign sp   = {32'd0, z_r} * {33'd0, step_scale};
  assign np   = 67'(pos_r) + 67'(drift)
              + (neg_r ? -$signed({3'b000, smag_r}) : $signed({3'b000, smag_r}));
  assign npos = (np > 67'sd2147483647) ? 32'sh7FFF_FFFF :
                (np < -67'sd2147483648) ? 32'sh8000_0000 : np[31:0];
  assign steps_n = (steps_r == CMAX) ? steps_r : steps_r + 1'b1;
  assign up_n    = (up_r == CMAX) ? up_r : up_r + 1'b1;
  assign dn_n    = (dn_r == CMAX) ? dn_r : dn_r + 1'b1;
  assign is_up   = $signed({npos[31], npos}) >= $signed({2'b00, upper_barrier});
  assign is_dn   = !is_up && ($signed({npos[31], npos}) <= -$signed({2'b00, lower_barrier}));

  assign busy = (state_r != B_IDLE);

  // Scale, then step and test
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      pos_r   <= '0;
      steps_r <= '0;
      up_r    <= '0;
      dn_r    <= '0;
      hit     <= 1'b0;
    end else begin
      hit <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (start) begin
            z_r     <= 32'(sample.prod >> ZSH);
            neg_r   <= sample.neg;
            state_r <= B_SCALE;
          end
        end
        B_SCALE: begin
          smag_r  <= sp >> FRACTION_BITS;
          state_r <= B_STEP;
        end
        B_STEP: begin
          state_r <= B_IDLE;
          if (is_up || is_dn) begin
            hit <= 1'b1;
            result.reached_upper  <= is_up;
            result.walk_length    <= clip(steps_n);
            result.final_position <= npos;
            result.upper_total    <= clip(is_up ? up_n : up_r);
            result.lower_total    <= clip(is_dn ? dn_n : dn_r);
            if (is_up) up_r <= up_n;
            else dn_r <= dn_n;
            pos_r   <= '0;
            steps_r <= '0;
          end else begin
            pos_r   <= npos;
            steps_r <= steps_n;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // A walk restarts after every hit
  assert property (@(posedge clk) disable iff (!rst_n) hit |-> (pos_r == '0 && steps_r == '0))
    else $error("walk not restarted after hit");
  assert property (@(posedge clk) disable iff (!rst_n) hit |-> $past(state_r == B_STEP))
    else $error("hit outside step");
  assert property (@(posedge clk) disable iff (!rst_n)
                   hit |-> (result.reached_upper ? up_r != '0 : dn_r != '0))
    else $error("tally not advanced");

endmodule

`default_nettype wire

FILE: tb/grw_walk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grw_walk_checker
// Watches the sample, result and register ports of the random walk block.
// Every accepted sample beat steps a local copy of the walk. A barrier hit
// queues the expected result beat. Each popped beat is compared field by
// field with the oldest expectation.
// ----------------------------------------------------------------------------
module grw_walk_checker
  import grw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  in_item_t    in_data,
  input  logic        out_pop,
  input  logic        out_empty,
  input  out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);

  localparam longint unsigned UNIT_Q30  = 64'd1 << 30;
  localparam longint unsigned TALLY_MAX = (64'd1 << COUNT_WIDTH) - 1;

  // Register copy
  longint unsigned upper_level, lower_level, scale_q;
  longint          drift_q;
  // Walk state
  longint          walk_pos;
  longint unsigned walk_steps, upper_count, lower_count;

  out_item_t finish_q[$];

  // -2 ln(u/2^32) in Q.28, log2 by repeated squaring
  function automatic longint unsigned neg_two_ln(input logic [31:0] u_raw);
    logic [31:0]     u;
    int              p;
    longint unsigned x, frac, t;
    u = (u_raw == 0) ? 32'd1 : u_raw;
    p = 31;
    frac = 0;
    while (u[p] == 1'b0) p--;
    x = longint'(u) << (31 - p);
    for (int i = 0; i < 32; i++) begin
      x = (x * x) >> 31;
      if (x >= (64'd1 << 32)) begin
        frac |= 64'd1 << (31 - i);
        x >>= 1;
      end
    end
    t = (longint'(32 - p) << 32) - frac;
    return ((t >> 4) * longint'(LN2_Q30)) >> 29;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  // cos(2 pi v) magnitude in Q.30, sign on the side
  function automatic longint unsigned turn_cosine(input logic [31:0] v, output bit neg);
    longint unsigned sdiv[4], cdiv[4];
    logic [31:0]     a;
    logic [1:0]      quad;
    longint unsigned low, mag, theta, t2, hs, hc, s, c;
    bit              fneg;
    sdiv = '{72, 42, 20, 6};
    cdiv = '{90, 56, 30, 12};
    a = v + 32'h2000_0000;
    quad = a[31:30];
    low = a[29:0];
    fneg = low < (64'd1 << 29);
    mag = fneg ? ((64'd1 << 29) - low) : (low - (64'd1 << 29));
    theta = (mag * longint'(PI_HALF_Q30)) >> 30;
    t2 = (theta * theta) >> 30;
    hs = UNIT_Q30;
    hc = UNIT_Q30;
    for (int i = 0; i < 4; i++) begin
      hs = UNIT_Q30 - ((t2 * hs) >> 30) / sdiv[i];
      hc = UNIT_Q30 - ((t2 * hc) >> 30) / cdiv[i];
    end
    s = (theta * hs) >> 30;
    c = UNIT_Q30 - ((t2 * hc) >> 30) / 2;
    case (quad)
      2'd0: begin neg = 1'b0;  return c; end
      2'd1: begin neg = !fneg; return s; end
      2'd2: begin neg = 1'b1;  return c; end
      default: begin neg = fneg; return s; end
    endcase
  endfunction

  function automatic longint unsigned bump(input longint unsigned c);
    return (c >= TALLY_MAX) ? TALLY_MAX : c + 1;
  endfunction

  function automatic logic [31:0] clip32(input longint unsigned c);
    return (c > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : c[31:0];
  endfunction

  // Advance the walk by one sample; queue a beat on a barrier hit
  task automatic walk_step(input in_item_t s);
    longint unsigned r, c, zmag, smag;
    longint          stepv, np;
    bit              cneg, up, down;
    out_item_t       hit;
    r = int_sqrt(neg_two_ln(s.uniform_radius) << 28);
    c = turn_cosine(s.uniform_angle, cneg);
    zmag = (r * c) >> (58 - FRACTION_BITS);
    smag = (zmag * scale_q) >> FRACTION_BITS;
    stepv = cneg ? -longint'(smag) : longint'(smag);
    np = walk_pos + stepv + drift_q;
    if (np > 64'sd2147483647) np = 64'sd2147483647;
    if (np < -64'sd2147483648) np = -64'sd2147483648;
    walk_pos = np;
    walk_steps = bump(walk_steps);
    up = walk_pos >= longint'(upper_level);
    down = !up && (walk_pos <= -longint'(lower_level));
    if (up || down) begin
      if (up) upper_count = bump(upper_count);
      else lower_count = bump(lower_count);
      hit.reached_upper = up;
      hit.walk_length = clip32(walk_steps);
      hit.final_position = walk_pos[31:0];
      hit.upper_total = clip32(upper_count);
      hit.lower_total = clip32(lower_count);
      finish_q.push_back(hit);
      walk_pos = 0;
      walk_steps = 0;
    end
  endtask

  function automatic int field_diff(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      upper_level = 64'd16777216;
      lower_level = 64'd33554432;
      scale_q = 64'd16777216;
      drift_q = 0;
      walk_pos = 0;
      walk_steps = 0;
      upper_count = 0;
      lower_count = 0;
      errors <= 0;
      finish_q.delete();
    end else begin
      // Register writes land when seen; user holds them to an idle walk
      if (cfg_we) begin
        case (cfg_index)
          REG_UPPER: upper_level = cfg_data[30:0];
          REG_LOWER: lower_level = cfg_data[30:0];
          REG_SCALE: scale_q = cfg_data[30:0];
          REG_DRIFT: drift_q = longint'(signed'(cfg_data));
          default: ;
        endcase
      end
      if (in_push && !in_full) walk_step(in_data);
      // Compare a popped beat against the oldest expectation
      if (out_pop && !out_empty) begin
        if (finish_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h",
                   $time, out_data);
          errors <= errors + 1;
        end else begin
          want = finish_q.pop_front();
          errors <= errors
            + field_diff("reached_upper", want.reached_upper, out_data.reached_upper)
            + field_diff("walk_length", want.walk_length, out_data.walk_length)
            + field_diff("final_position", want.final_position, out_data.final_position)
            + field_diff("upper_total", want.upper_total, out_data.upper_total)
            + field_diff("lower_total", want.lower_total, out_data.lower_total);
        end
      end
    end
    pending <= finish_q.size();
  end

endmodule

FILE: tb/tb_gaussian_random_walk_barrier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gaussian_random_walk_barrier_core
// Drives uniform sample pairs into the random walk block under several
// register settings and idle patterns, and gives the verdict from the
// checker's error count.
// ----------------------------------------------------------------------------
module tb_gaussian_random_walk_barrier_core;
  import grw_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 600;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  in_item_t    in_data = '0;
  logic        in_full;
  logic        out_empty;
  logic        out_pop = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_UPPER;
  logic [31:0] cfg_data = '0;

  int errors, pending;
  int cycles = 0;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;

  gaussian_random_walk_barrier_core dut (
    .clk, .rst_n, .in_push, .in_data, .in_full,
    .out_empty, .out_pop, .out_data, .cfg_we, .cfg_index, .cfg_data
  );

  grw_walk_checker checker_i (
    .clk, .rst_n, .in_push, .in_full, .in_data, .out_pop, .out_empty,
    .out_data, .cfg_we, .cfg_index, .cfg_data, .errors, .pending
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Randomly stall the result side
  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // Push one sample beat, idling first at random; hold it until taken
  task automatic push_sample(input logic [31:0] radius, input logic [31:0] angle);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= '{uniform_radius: radius, uniform_angle: angle};
    in_push <= 1'b1;
    forever begin
      @(posedge clk);
      if (!in_full) break;
    end
  endtask

  // Drain outstanding walks, then let any stepping sample settle
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Present one register write for one edge; the caller drops the enable
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_regs(input logic [31:0] up, input logic [31:0] lo,
                           input logic [31:0] sc, input logic [31:0] dr);
    write_reg(REG_UPPER, up);
    write_reg(REG_LOWER, lo);
    write_reg(REG_SCALE, sc);
    write_reg(REG_DRIFT, dr);
    cfg_we <= 1'b0;
  endtask

  logic [31:0] radius;

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: radius extremes (zero counts as one), quadrant edges of the angle
    push_sample(32'h0000_0000, 32'h0000_0000);
    push_sample(32'h0000_0001, 32'h4000_0000);
    push_sample(32'hFFFF_FFFF, 32'h8000_0000);
    push_sample(32'h8000_0000, 32'hC000_0000);
    push_sample(32'h7FFF_FFFF, 32'hFFFF_FFFF);
    push_sample(32'h0000_0002, 32'h2000_0000);
    push_sample(32'h0001_0000, 32'h6000_0000);
    push_sample(32'h0000_0003, 32'hA000_0000);
    push_sample(32'h0000_0001, 32'hE000_0000);
    push_sample(32'h5555_5555, 32'h1FFF_FFFF);
    push_sample(32'hAAAA_AAAA, 32'h2000_0001);
    push_sample(32'h0000_0001, 32'h8000_0000);
    drain();

    // Saturated position hits the top barrier at its maximum
    load_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF);
    push_sample(32'h0000_0001, 32'h0000_0000);
    push_sample(32'hFFFF_FFFF, 32'h8000_0000);
    drain();
    // Saturated position hits the bottom barrier
    load_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000);
    push_sample(32'h0000_0001, 32'h0000_0000);
    push_sample(32'h1234_5678, 32'h8765_4321);
    drain();
    // Tightest barriers with the largest scale
    load_regs(32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000);
    push_sample(32'h0000_0001, 32'h4000_0000);
    push_sample(32'h0000_0001, 32'h0000_0000);
    push_sample(32'hFFFF_FFFF, 32'h4000_0000);
    drain();

    // Random: register settings crossed with idle patterns
    for (int cfg = 0; cfg < 5; cfg++) begin
      for (int mode = 0; mode < 4; mode++) begin
        case (cfg)
          0: load_regs(32'h0100_0000, 32'h0200_0000, 32'h0100_0000, 32'h0000_0000);
          1: load_regs(32'h0300_0000, 32'h0300_0000, 32'h0080_0000, 32'hFFF0_0000);
          2: load_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF);
          3: load_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000);
          default: load_regs($urandom_range(32'h0400_0000, 1),
                             $urandom_range(32'h0400_0000, 1),
                             $urandom | 32'h8000_0000, $urandom);
        endcase
        send_idle_pct = (mode == 1 || mode == 3) ? ((mode == 1) ? 79 : 31) : 0;
        pop_stall_pct = (mode == 2 || mode == 3) ? ((mode == 2) ? 79 : 31) : 0;
        for (int n = 0; n < 80; n++) begin
          radius = $urandom;
          // Reach the deep end of the log range now and then
          if ($urandom_range(3) == 0) radius = radius >> $urandom_range(31);
          push_sample(radius, $urandom);
        end
        drain();
        send_idle_pct = 0;
        pop_stall_pct = 0;
      end
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/grw_pkg.sv
rtl/grw_front.sv
rtl/grw_back.sv
rtl/gaussian_random_walk_barrier_core.sv
tb/grw_walk_checker.sv
tb/tb_gaussian_random_walk_barrier_core.sv
